/* src/bmpw_pkg.sv */
// ----------------------------------------------------------------------------
// bmpw_pkg
// shared types and constants for the 24-bit bmp frame buffer writer
// ----------------------------------------------------------------------------
package bmpw_pkg;

  localparam int unsigned MAX_SIDE = 65535;

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_M = 8'h4d;
  localparam logic [7:0] DEPTH_24 = 8'd24;

  localparam logic [5:0] POS_MAGIC0 = 6'd0;
  localparam logic [5:0] POS_MAGIC1 = 6'd1;
  localparam logic [5:0] POS_WIDTH0 = 6'd18;
  localparam logic [5:0] POS_WIDTH1 = 6'd19;
  localparam logic [5:0] POS_WIDTH2 = 6'd20;
  localparam logic [5:0] POS_WIDTH3 = 6'd21;
  localparam logic [5:0] POS_HEIGHT0 = 6'd22;
  localparam logic [5:0] POS_HEIGHT1 = 6'd23;
  localparam logic [5:0] POS_HEIGHT2 = 6'd24;
  localparam logic [5:0] POS_HEIGHT3 = 6'd25;
  localparam logic [5:0] POS_DEPTH0 = 6'd28;
  localparam logic [5:0] POS_DEPTH1 = 6'd29;
  localparam logic [5:0] POS_LAST = 6'd53;

  localparam logic [6:0] BRIGHT_MAX = 7'd100;

  // floor(v * b / 800) as (v * b * SCALE_RECIP) >> SCALE_SHIFT, exact for v * b <= 25500
  localparam logic [15:0] SCALE_RECIP = 16'd41944;
  localparam int unsigned SCALE_SHIFT = 25;

  localparam logic [3:0] ADDR_BRIGHTNESS = 4'h0;
  localparam logic [3:0] ADDR_HALF = 4'h4;
  localparam logic [3:0] ADDR_WIDE = 4'h8;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_HALF = 2'd1;
  localparam logic [1:0] REG_WIDE = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BAD_HEADER = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [6:0] brightness_percent;
    logic       half_scale;
    logic       wide_screen;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [18:0] address;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
  } event_t;

endpackage

/* src/bmpw_front.sv */
// ----------------------------------------------------------------------------
// bmpw_front
// byte parser: header checks, row and column walk, centering and clipping
// ----------------------------------------------------------------------------
module bmpw_front (
  input  logic             clk,
  input  logic             rst,
  input  bmpw_pkg::cfg_t   cfg,
  input  logic [7:0]       file_byte,
  input  logic             file_start,
  input  logic             file_valid,
  output logic             file_stall,
  input  logic             queue_full,
  output logic             push,
  output bmpw_pkg::event_t push_data
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [5:0]  pos, pos_next;
  logic [15:0] width, width_next;
  logic        width_hi, width_hi_next;
  logic [15:0] height, height_next;
  logic        height_hi, height_hi_next;
  logic [7:0]  depth_lo, depth_lo_next;
  logic [15:0] row_left, row_left_next;
  logic [15:0] col, col_next;
  logic [1:0]  bip, bip_next;
  logic [7:0]  blue_hold, blue_hold_next;
  logic [7:0]  green_hold, green_hold_next;
  logic [1:0]  pad, pad_next;
  logic [16:0] off_x, off_x_next;
  logic [16:0] off_y, off_y_next;

  logic        accept;
  logic        reject;
  logic        pix_event;
  logic        pix_visible;
  logic [15:0] hh, ww, ysel, xsel;
  logic [17:0] dy, dx, dy_r, dx_r;
  logic [17:0] cy, cx;
  logic [15:0] col_inc;
  logic        finish_row;

  assign file_stall = queue_full;
  assign accept = file_valid && !file_stall;

  // centering offsets, truncated toward zero
  always_comb begin
    hh = cfg.half_scale ? {1'b0, height_next[15:1]} : height_next;
    ww = cfg.half_scale ? {1'b0, width_next[15:1]} : width_next;
    dy = 18'sd512 - $signed({2'b00, hh});
    dx = (cfg.wide_screen ? 18'sd768 : 18'sd512) - $signed({2'b00, ww});
    dy_r = dy + {17'd0, dy[17]};
    dx_r = dx + {17'd0, dx[17]};
  end

  // screen position of the pixel that completes with this beat
  always_comb begin
    ysel = cfg.half_scale ? {1'b0, row_left[15:1]} : row_left;
    xsel = cfg.half_scale ? {1'b0, col[15:1]} : col;
    cy = {off_y[16], off_y} + {2'b00, ysel};
    cx = {off_x[16], off_x} + {2'b00, xsel};
    pix_visible = !cy[17] && (cy[16:9] == 8'd0) && !cx[17] &&
                  (cfg.wide_screen ? ((cx[16:10] == 7'd0) && (cx[9:0] <= 10'd767))
                                   : (cx[16:9] == 8'd0)) &&
                  !(cfg.half_scale && (row_left[0] || col[0]));
  end

  always_comb begin
    phase_next = file_start ? PH_HEADER : phase;
    pos_next = file_start ? 6'd0 : pos;
    width_next = file_start ? 16'd0 : width;
    width_hi_next = file_start ? 1'b0 : width_hi;
    height_next = file_start ? 16'd0 : height;
    height_hi_next = file_start ? 1'b0 : height_hi;
    depth_lo_next = file_start ? 8'd0 : depth_lo;
    col_next = file_start ? 16'd0 : col;
    bip_next = file_start ? 2'd0 : bip;
    pad_next = file_start ? 2'd0 : pad;
    row_left_next = row_left;
    blue_hold_next = blue_hold;
    green_hold_next = green_hold;
    off_x_next = off_x;
    off_y_next = off_y;
    reject = 1'b0;
    pix_event = 1'b0;
    finish_row = 1'b0;
    col_inc = col_next + 16'd1;

    case (phase_next)
      PH_HEADER: begin
        pos_next = pos_next + 6'd1;
        case (file_start ? 6'd0 : pos)
          bmpw_pkg::POS_MAGIC0: reject = (file_byte != bmpw_pkg::MAGIC_B);
          bmpw_pkg::POS_MAGIC1: reject = (file_byte != bmpw_pkg::MAGIC_M);
          bmpw_pkg::POS_WIDTH0: width_next[7:0] = file_byte;
          bmpw_pkg::POS_WIDTH1: width_next[15:8] = file_byte;
          bmpw_pkg::POS_WIDTH2: width_hi_next = (file_byte != 8'd0);
          bmpw_pkg::POS_WIDTH3: reject = width_hi || (file_byte != 8'd0);
          bmpw_pkg::POS_HEIGHT0: height_next[7:0] = file_byte;
          bmpw_pkg::POS_HEIGHT1: height_next[15:8] = file_byte;
          bmpw_pkg::POS_HEIGHT2: height_hi_next = (file_byte != 8'd0);
          bmpw_pkg::POS_HEIGHT3: reject = height_hi || (file_byte != 8'd0);
          bmpw_pkg::POS_DEPTH0: depth_lo_next = file_byte;
          bmpw_pkg::POS_DEPTH1: begin
            reject = (file_byte != 8'd0) || (depth_lo != bmpw_pkg::DEPTH_24);
          end
          bmpw_pkg::POS_LAST: begin
            off_y_next = dy_r[17:1];
            off_x_next = dx_r[17:1];
            row_left_next = height_next - 16'd1;
            col_next = 16'd0;
            bip_next = 2'd0;
            pad_next = 2'd0;
            phase_next = ((width_next == 16'd0) || (height_next == 16'd0)) ? PH_DONE
                                                                          : PH_PIXELS;
          end
          default: ;
        endcase
        if (reject) begin
          phase_next = PH_DONE;
        end
      end
      PH_PIXELS: begin
        if (pad != 2'd0) begin
          pad_next = pad - 2'd1;
          finish_row = (pad == 2'd1);
        end else if (bip == 2'd0) begin
          blue_hold_next = file_byte;
          bip_next = 2'd1;
        end else if (bip == 2'd1) begin
          green_hold_next = file_byte;
          bip_next = 2'd2;
        end else begin
          pix_event = pix_visible;
          bip_next = 2'd0;
          col_next = col_inc;
          if (col_inc == width) begin
            pad_next = width[1:0];
            finish_row = (width[1:0] == 2'd0);
          end
        end
        if (finish_row) begin
          col_next = 16'd0;
          bip_next = 2'd0;
          pad_next = 2'd0;
          if (row_left == 16'd0) begin
            phase_next = PH_DONE;
          end else begin
            row_left_next = row_left - 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign push = accept && (reject || pix_event);

  always_comb begin
    push_data.kind = reject ? bmpw_pkg::KIND_BAD_HEADER : bmpw_pkg::KIND_PIXEL;
    push_data.address = reject ? 19'd0 :
                        cfg.wide_screen ? {cy[8:0], cx[9:0]} : {1'b0, cy[8:0], cx[8:0]};
    push_data.green = green_hold;
    push_data.red = file_byte;
    push_data.blue = blue_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      pos <= 6'd0;
      width <= 16'd0;
      width_hi <= 1'b0;
      height <= 16'd0;
      height_hi <= 1'b0;
      depth_lo <= 8'd0;
      row_left <= 16'd0;
      col <= 16'd0;
      bip <= 2'd0;
      pad <= 2'd0;
      off_x <= 17'd0;
      off_y <= 17'd0;
    end else if (accept) begin
      phase <= phase_next;
      pos <= pos_next;
      width <= width_next;
      width_hi <= width_hi_next;
      height <= height_next;
      height_hi <= height_hi_next;
      depth_lo <= depth_lo_next;
      row_left <= row_left_next;
      col <= col_next;
      bip <= bip_next;
      pad <= pad_next;
      off_x <= off_x_next;
      off_y <= off_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blue_hold <= blue_hold_next;
      green_hold <= green_hold_next;
    end
  end

endmodule

/* src/bmpw_queue.sv */
// ----------------------------------------------------------------------------
// bmpw_queue
// small fifo of pixel and reject events between parser and color scaler
// ----------------------------------------------------------------------------
module bmpw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bmpw_pkg::event_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output bmpw_pkg::event_t pop_data
);

  bmpw_pkg::event_t slots [bmpw_pkg::QUEUE_DEPTH];
  logic [bmpw_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [bmpw_pkg::QUEUE_AW:0]   count;
  logic do_pop;

  assign full = (count == (bmpw_pkg::QUEUE_AW + 1)'(bmpw_pkg::QUEUE_DEPTH));
  assign avail = (count != '0);
  assign do_pop = pop && avail;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/bmpw_back.sv */
// ----------------------------------------------------------------------------
// bmpw_back
// color scaler: brightness scaling of each channel and the result register
// ----------------------------------------------------------------------------
module bmpw_back (
  input  logic             clk,
  input  logic             rst,
  input  bmpw_pkg::cfg_t   cfg,
  input  logic             avail,
  input  bmpw_pkg::event_t pop_data,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             result_kind,
  output logic [18:0]      screen_address,
  output logic [15:0]      pixel_word
);

  localparam int unsigned S = bmpw_pkg::SCALE_SHIFT;

  logic        advance;
  logic [6:0]  bright;

  logic        v1, v2;
  logic        kind1, kind2;
  logic [18:0] addr1, addr2;
  logic [14:0] pg, pr, pb;
  logic [30:0] qg, qr, qb;

  assign advance = !(result_valid && result_stall);
  assign pop = advance && avail;
  assign bright = (cfg.brightness_percent > bmpw_pkg::BRIGHT_MAX) ? bmpw_pkg::BRIGHT_MAX
                                                                  : cfg.brightness_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1 <= avail;
      v2 <= v1;
      result_valid <= v2;
    end
  end

  // channel times brightness
  always_ff @(posedge clk) begin
    if (advance) begin
      kind1 <= pop_data.kind;
      addr1 <= pop_data.address;
      pg <= {7'd0, pop_data.green} * {8'd0, bright};
      pr <= {7'd0, pop_data.red} * {8'd0, bright};
      pb <= {7'd0, pop_data.blue} * {8'd0, bright};
    end
  end

  // divide by 800 through the reciprocal
  always_ff @(posedge clk) begin
    if (advance) begin
      kind2 <= kind1;
      addr2 <= addr1;
      qg <= {16'd0, pg} * {15'd0, bmpw_pkg::SCALE_RECIP};
      qr <= {16'd0, pr} * {15'd0, bmpw_pkg::SCALE_RECIP};
      qb <= {16'd0, pb} * {15'd0, bmpw_pkg::SCALE_RECIP};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_kind <= kind2;
      screen_address <= addr2;
      pixel_word <= (kind2 == bmpw_pkg::KIND_BAD_HEADER) ? 16'd0 :
                    {qg[S+4:S], qr[S+4:S], qb[S+4:S], 1'b1};
    end
  end

endmodule

/* src/bmp24_to_framebuffer_writer.sv */
// ----------------------------------------------------------------------------
// bmp24_to_framebuffer_writer
// 24-bit bmp byte stream to centered, clipped, brightness-scaled screen writes
// ----------------------------------------------------------------------------
// throughput: one file byte per cycle while file_stall is low, one result per
//   cycle while result_stall is low; a result's event passes, in order, the
//   event queue, product stage, reciprocal stage and result register
// reset: parser waits for a file start, queue and pipeline empty,
//   brightness 100, half scale off, wide screen off
module bmp24_to_framebuffer_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  file_byte,
  input  logic        file_start,
  input  logic        file_valid,
  output logic        file_stall,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic [18:0] screen_address,
  output logic [15:0] pixel_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bmpw_pkg::cfg_t   cfg;
  bmpw_pkg::event_t push_data, pop_data;
  logic             push, pop, queue_full, avail;
  logic             cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness_percent <= bmpw_pkg::BRIGHT_MAX;
      cfg.half_scale <= 1'b0;
      cfg.wide_screen <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        bmpw_pkg::REG_BRIGHTNESS: cfg.brightness_percent <= pwdata[6:0];
        bmpw_pkg::REG_HALF: cfg.half_scale <= pwdata[0];
        bmpw_pkg::REG_WIDE: cfg.wide_screen <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      bmpw_pkg::ADDR_BRIGHTNESS: prdata = {25'd0, cfg.brightness_percent};
      bmpw_pkg::ADDR_HALF: prdata = {31'd0, cfg.half_scale};
      bmpw_pkg::ADDR_WIDE: prdata = {31'd0, cfg.wide_screen};
      default: prdata = 32'd0;
    endcase
  end

  bmpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .file_byte  (file_byte),
    .file_start (file_start),
    .file_valid (file_valid),
    .file_stall (file_stall),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  bmpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  bmpw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .avail          (avail),
    .pop_data       (pop_data),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_kind    (result_kind),
    .screen_address (screen_address),
    .pixel_word     (pixel_word)
  );

endmodule
